FILE: hdl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants of the short frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 64;

   localparam logic [7:0] START_CODE       = 8'h10;
   localparam logic [7:0] END_CODE         = 8'h16;
   localparam logic [7:0] DEVICE_MAX       = 8'd99;
   localparam logic [7:0] DEVICE_BROADCAST = 8'd255;

   localparam int unsigned COUNT_OUT_W = 7;
   localparam int unsigned RSP_DATA_W  = 40;

   typedef enum logic [3:0] {
      PH_START   = 4'b0001,
      PH_DEVICE  = 4'b0010,
      PH_REQUEST = 4'b0100,
      PH_BODY    = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      V_OK     = 3'd0,
      V_START  = 3'd1,
      V_DEVICE = 3'd2,
      V_TRUNC  = 3'd3,
      V_CSUM   = 3'd4,
      V_END    = 3'd5,
      V_LONG   = 3'd6
   } verdict_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               payload_byte;
      logic [7:0]               device_number;
      logic [7:0]               request_code;
      logic [COUNT_OUT_W-1:0]   payload_count;
      verdict_type              verdict;
   } result_type;

endpackage

FILE: hdl/short_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_frame_decoder_core
// decodes short frames byte by byte into payload and verdict results
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | tdata rx_byte, tlast frame_last
//  rsp     | out | rsp_tvalid/rsp_tready | tuser kind, tdata result fields
//
//  one byte per cycle while req_tready is high: each transaction updates the frame state
//  a payload result appears one byte late, the verdict with the last byte
//  results sit in an output register backed by a one-entry skid stage,
//  req_tready drops only while both hold a result
//  reset is synchronous and returns the frame state to waiting for a start
// ----------------------------------------------------------------------------
module short_frame_decoder_core #(
   parameter int unsigned MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input byte stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   input  logic                             req_tlast,   // frame_last
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] payload_byte, [15:8] device_number, [23:16] request_code,
   // [30:24] payload_count, [33:31] verdict, [39:34] zero
   output logic [sfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser    // kind
);
   import sfd_pkg::*;

   logic       req_fire;
   logic       res_valid;
   result_type res_data;
   result_type out_data;

   // byte accepted into the frame state this cycle
   assign req_fire = req_tvalid && req_tready;

   sfd_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .rx_byte    (req_tdata),
      .frame_last (req_tlast),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   sfd_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // pack result fields, first field in the low bits
   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {6'b0, out_data.verdict, out_data.payload_count,
                       out_data.request_code, out_data.device_number,
                       out_data.payload_byte};

endmodule

FILE: hdl/sfd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_frame_fsm
// per-byte frame state update and result generation
// ----------------------------------------------------------------------------
module sfd_frame_fsm #(
   parameter int unsigned MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   input  logic [7:0]         rx_byte,
   input  logic               frame_last,
   output logic               res_valid,
   output sfd_pkg::result_type res_data
);
   import sfd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       device_ff, device_in;
   logic [7:0]       request_ff, request_in;
   verdict_type      error_ff, error_in;

   logic [7:0]       expect_sum;
   logic             device_bad;

   assign expect_sum = ~sum_ff;
   assign device_bad = (rx_byte != DEVICE_BROADCAST) && (rx_byte > DEVICE_MAX);

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      device_in     = device_ff;
      request_in    = request_ff;
      error_in      = error_ff;
      res_valid     = 1'b0;
      res_data      = '0;

      if (in_fire) begin
         case (phase_ff)
            PH_START: begin
               if (rx_byte != START_CODE && error_in == V_OK) error_in = V_START;
               phase_in = PH_DEVICE;
               if (frame_last && error_in == V_OK) error_in = V_TRUNC;
            end
            PH_DEVICE: begin
               device_in = rx_byte;
               sum_in    = rx_byte;
               if (device_bad && error_in == V_OK) error_in = V_DEVICE;
               phase_in = PH_REQUEST;
               if (frame_last && error_in == V_OK) error_in = V_TRUNC;
            end
            PH_REQUEST: begin
               request_in = rx_byte;
               sum_in     = sum_ff + rx_byte;
               phase_in   = PH_BODY;
               if (frame_last && error_in == V_OK) error_in = V_TRUNC;
            end
            PH_BODY: begin
               if (frame_last) begin
                  // held byte, if any, is the checksum and this byte the end
                  if (held_valid_ff) begin
                     if (held_ff != expect_sum) begin
                        if (error_in == V_OK) error_in = V_CSUM;
                     end else if (rx_byte != END_CODE) begin
                        if (error_in == V_OK) error_in = V_END;
                     end
                  end else begin
                     if (error_in == V_OK) begin
                        error_in = (rx_byte != expect_sum) ? V_CSUM : V_TRUNC;
                     end
                  end
               end else begin
                  if (held_valid_ff && error_ff == V_OK) begin
                     if (count_ff >= CNT_LIMIT) begin
                        error_in = V_LONG;
                     end else begin
                        // previous byte cannot be the checksum: confirm it
                        sum_in                 = sum_ff + held_ff;
                        count_in               = count_ff + 1'b1;
                        res_valid              = 1'b1;
                        res_data.kind          = KIND_PAYLOAD;
                        res_data.payload_byte  = held_ff;
                     end
                  end
                  held_in       = rx_byte;
                  held_valid_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase

         if (frame_last) begin
            res_valid              = 1'b1;
            res_data.kind          = KIND_VERDICT;
            res_data.payload_byte  = '0;
            res_data.device_number = device_in;
            res_data.request_code  = request_in;
            res_data.payload_count = COUNT_OUT_W'(count_in);
            res_data.verdict       = error_in;
            phase_in      = PH_START;
            sum_in        = '0;
            held_in       = '0;
            held_valid_in = 1'b0;
            count_in      = '0;
            device_in     = '0;
            request_in    = '0;
            error_in      = V_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         sum_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         device_ff     <= '0;
         request_ff    <= '0;
         error_ff      <= V_OK;
      end else begin
         phase_ff      <= phase_in;
         sum_ff        <= sum_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         device_ff     <= device_in;
         request_ff    <= request_in;
         error_ff      <= error_in;
      end
   end

endmodule

FILE: hdl/sfd_out_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_buffer
// result register with a skid stage behind it
// ----------------------------------------------------------------------------
module sfd_out_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfd_pkg::result_type push_data,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output sfd_pkg::result_type out_data
);
   import sfd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_take;

   assign out_take  = out_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push can happen while the skid stage is full
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = push;
         out_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: hdl/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// port-level checks of the result stream
// ----------------------------------------------------------------------------
module sfd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // payload transaction carries zeros in all verdict fields
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[39:8] == 32'd0)
      else $error("payload result with nonzero verdict fields");

   // verdict transaction has no payload byte, a defined code and zero padding
   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == 8'd0 && rsp_tdata[33:31] != 3'd7
         && rsp_tdata[39:34] == 6'd0)
      else $error("malformed verdict result");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind short_frame_decoder_core sfd_checker u_sfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
